FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, sizes and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Queue depth and field widths.
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int PRIO_W = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Action codes of an input beat.
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // One stored entry.
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
    logic [PRIO_W-1:0]        prio;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } spq_op_t;

endpackage

FILE: design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic            clk,
  input  logic            rst,
  input  spq_pkg::spq_op_t op,
  input  logic            left_keep,
  input  spq_pkg::entry_t left_entry,
  input  spq_pkg::entry_t right_entry,
  output logic            keep,
  output spq_pkg::entry_t entry
);
  import spq_pkg::*;

  entry_t entry_next;

  // The entry stays on an insert when it sorts at or before the new one.
  assign keep = entry.valid && (entry.prio <= op.prio);

  // Choose the next contents of this slot.
  always_comb begin
    entry_next = entry;
    if (op.enq) begin
      if (!keep) begin
        if (left_keep) begin
          entry_next.valid = 1'b1;
          entry_next.data  = op.data;
          entry_next.prio  = op.prio;
        end else begin
          entry_next = left_entry;
        end
      end
    end else if (op.deq) begin
      entry_next = right_entry;
    end
  end

  // Only the valid flag needs a reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.data <= entry_next.data;
    entry.prio <= entry_next.prio;
  end

endmodule

FILE: design/sorted_priority_queue_core.sv
// The result beat of an accepted input beat is registered and appears in the cycle after it.
// Throughput: one item per cycle while result beats are taken; every slot of the cell chain updates at once.
// The output register lets a new beat in while the current result is taken.
// Reset (synchronous, active high) empties the queue and drops any result.
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded stable min-priority queue built as a chain of sorting cells.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic                                action,
  input  logic signed [spq_pkg::DATA_W-1:0]   item_data,
  input  logic [spq_pkg::PRIO_W-1:0]          item_priority,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                out_valid,
  output logic signed [spq_pkg::DATA_W-1:0]   out_data,
  output logic [spq_pkg::PRIO_W-1:0]          out_priority,
  output logic [spq_pkg::CNT_W-1:0]           entry_count,
  output logic [1:0]                          status
);
  import spq_pkg::*;

  logic              accept;
  logic              full;
  logic              empty;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  spq_op_t           op;
  entry_t            cells   [DEPTH];
  logic              keeps   [DEPTH];
  entry_t            zero_entry;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign full       = (count == CNT_W'(DEPTH));
  assign empty      = (count == '0);
  assign zero_entry = '0;

  // Broadcast the operation to the chain only when it changes the queue.
  always_comb begin
    op.enq  = accept && (action == ACT_ENQ) && !full;
    op.deq  = accept && (action == ACT_DEQ) && !empty;
    op.data = item_data;
    op.prio = item_priority;
  end

  // Row of cells; the first cell inserts whenever its own entry does not stay.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .op         (op),
        .left_keep  (1'b1),
        .left_entry (zero_entry),
        .right_entry((DEPTH > 1) ? cells[(i + 1) % DEPTH] : zero_entry),
        .keep       (keeps[i]),
        .entry      (cells[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      spq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .op         (op),
        .left_keep  (keeps[i-1]),
        .left_entry (cells[i-1]),
        .right_entry(zero_entry),
        .keep       (keeps[i]),
        .entry      (cells[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .op         (op),
        .left_keep  (keeps[i-1]),
        .left_entry (cells[i-1]),
        .right_entry(cells[i+1]),
        .keep       (keeps[i]),
        .entry      (cells[i])
      );
    end
  end

  // Entry count follows the operations that were carried out.
  always_comb begin
    count_next = count;
    if (op.enq) begin
      count_next = count + CNT_W'(1);
    end else if (op.deq) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_valid    <= op.deq;
      out_data     <= op.deq ? cells[0].data : '0;
      out_priority <= op.deq ? cells[0].prio : '0;
      entry_count  <= count_next;
      if ((action == ACT_ENQ) && full) begin
        status <= ST_FULL;
      end else if ((action == ACT_DEQ) && empty) begin
        status <= ST_EMPTY;
      end else begin
        status <= ST_OK;
      end
    end
  end

endmodule

FILE: design/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_valid,
  input logic                              item_ready,
  input logic                              result_valid,
  input logic                              result_ready,
  input logic                              out_valid,
  input logic [spq_pkg::CNT_W-1:0]         entry_count,
  input logic [1:0]                        status
);
  import spq_pkg::*;

  // A pending result beat holds until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  // A refused enqueue reports a full queue.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_FULL) |-> entry_count == CNT_W'(DEPTH))
    else $error("full status with count below depth");

  // An empty dequeue reports no entries and removes nothing.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_EMPTY) |-> (entry_count == '0) && !out_valid)
    else $error("empty status with entries held");

  // A removed entry always comes with ok status and a count below depth.
  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_valid |->
      (status == ST_OK) && (entry_count < CNT_W'(DEPTH)))
    else $error("removed entry with bad status or count");

  // The input is refused only while a result beat waits.
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |-> result_valid && !result_ready)
    else $error("input refused without a stalled result");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_ready  (item_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .out_valid   (out_valid),
  .entry_count (entry_count),
  .status      (status)
);

FILE: sim/queue_order_checker.sv
// ----------------------------------------------------------------------------
// queue_order_checker
// Watches both channels of the sorted priority queue, keeps a shadow copy of
// the sorted entries, and compares every result beat with its prediction.
// ----------------------------------------------------------------------------
module queue_order_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  input  logic                                item_ready,
  input  logic                                action,
  input  logic signed [spq_pkg::DATA_W-1:0]   item_data,
  input  logic [spq_pkg::PRIO_W-1:0]          item_priority,
  input  logic                                result_valid,
  input  logic                                result_ready,
  input  logic                                out_valid,
  input  logic signed [spq_pkg::DATA_W-1:0]   out_data,
  input  logic [spq_pkg::PRIO_W-1:0]          out_priority,
  input  logic [spq_pkg::CNT_W-1:0]           entry_count,
  input  logic [1:0]                          status,
  output int                                  mismatches,
  output int                                  outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  // One predicted result beat.
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
    logic [PRIO_W-1:0]        prio;
    logic [CNT_W-1:0]         count;
    status_t                  status;
  } queue_result_t;

  // Shadow copy of the sorted entries, head at index zero.
  logic signed [DATA_W-1:0] shadow_data [DEPTH];
  logic [PRIO_W-1:0]        shadow_prio [DEPTH];
  int                       shadow_count;

  // Predicted results not yet seen on the result channel, oldest first.
  queue_result_t awaited_results [$];

  // Applies one input beat to the shadow queue and returns its result.
  function automatic queue_result_t apply_beat(logic act, logic signed [DATA_W-1:0] d,
                                               logic [PRIO_W-1:0] p);
    queue_result_t r;
    int            pos;
    r = '0;
    r.status = ST_OK;
    if (act == ACT_ENQ) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // New entry goes behind every entry of equal or lower value.
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= p) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_data[i] = shadow_data[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_data[pos] = d;
        shadow_prio[pos] = p;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.valid = 1'b1;
      r.data  = shadow_data[0];
      r.prio  = shadow_prio[0];
      for (int i = 1; i < shadow_count; i++) begin
        shadow_data[i-1] = shadow_data[i];
        shadow_prio[i-1] = shadow_prio[i];
      end
      shadow_count--;
      shadow_data[shadow_count] = '0;
      shadow_prio[shadow_count] = '0;
    end
    r.count = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    shadow_count = 0;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_data[i] = '0;
      shadow_prio[i] = '0;
    end
  end

  // Compare the result beat first: it always belongs to an earlier input beat.
  always @(posedge clk) begin
    queue_result_t exp_r;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          if (mismatches < 10)
            $display({"%0t: result beat with no prediction waiting: ",
                      "valid=%0d data=%0d prio=%0d count=%0d status=%0d"},
                     $time, out_valid, out_data, out_priority, entry_count, status);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_valid !== exp_r.valid || out_data !== exp_r.data ||
              out_priority !== exp_r.prio || entry_count !== exp_r.count ||
              status !== exp_r.status) begin
            if (mismatches < 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected valid=%0d data=%0d prio=%0d count=%0d status=%0d",
                       exp_r.valid, exp_r.data, exp_r.prio, exp_r.count, exp_r.status);
              $display("  actual   valid=%0d data=%0d prio=%0d count=%0d status=%0d",
                       out_valid, out_data, out_priority, entry_count, status);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (item_valid && item_ready)
        awaited_results.push_back(apply_beat(action, item_data, item_priority));
      outstanding <= awaited_results.size();
    end
  end

endmodule

FILE: sim/sorted_priority_queue_core_test.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_test
// Drives enqueue and dequeue beats with random idling on both channels into
// the sorted priority queue; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  logic                     clk;
  logic                     rst;
  logic                     item_valid;
  logic                     item_ready;
  logic                     action;
  logic signed [DATA_W-1:0] item_data;
  logic [PRIO_W-1:0]        item_priority;
  logic                     result_valid;
  logic                     result_ready;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_data;
  logic [PRIO_W-1:0]        out_priority;
  logic [CNT_W-1:0]         entry_count;
  logic [1:0]               status;
  int                       mismatches;
  int                       outstanding;

  // When set, neither side idles between beats.
  bit                       steady;
  int                       beats_sent;

  sorted_priority_queue_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .item_data    (item_data),
    .item_priority(item_priority),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_priority (out_priority),
    .entry_count  (entry_count),
    .status       (status)
  );

  queue_order_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .item_data    (item_data),
    .item_priority(item_priority),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_priority (out_priority),
    .entry_count  (entry_count),
    .status       (status),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // 10 ns clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Idle cycles before the next beat on either channel.
  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  // Mostly a few small values so that ties are common, plus the extremes.
  function automatic logic [PRIO_W-1:0] draw_priority();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4, 5: return PRIO_W'($urandom_range(0, 7));
      6:       return PRIO_W'($urandom_range(65528, 65535));
      default: return PRIO_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] draw_data();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Presents one input beat at a falling edge and holds it until accepted.
  task automatic send_beat(logic act, logic signed [DATA_W-1:0] d, logic [PRIO_W-1:0] p);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action        = act;
    item_data     = d;
    item_priority = p;
    item_valid    = 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Pauses the sender until every predicted result has come back.
  task automatic drain_results();
    item_valid = 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  // Result side: random stalls before taking each result beat.
  initial begin
    int stall;
    result_ready = 1'b0;
    @(negedge clk);
    wait (!rst);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        result_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready = 1'b1;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    int phase_len;
    int enq_pct;
    rst           = 1'b1;
    item_valid    = 1'b0;
    action        = ACT_ENQ;
    item_data     = '0;
    item_priority = '0;
    steady        = 1'b0;
    beats_sent    = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed: dequeue while empty, fill with ties and extremes, refused
    // enqueue while full, then a few dequeues.
    send_beat(ACT_DEQ, '1, '1);
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: item_priority = 16'hFFFF;
        1: item_priority = 16'h0000;
        2: item_priority = 16'h0005;
        default: item_priority = 16'h8000;
      endcase
      send_beat(ACT_ENQ,
                (i == 0) ? 32'h8000_0000 : (i == 1) ? 32'h7FFF_FFFF :
                (i % 2) ? (32'hAAAA_AAAA ^ i) : (32'h5555_5555 + i),
                item_priority);
    end
    send_beat(ACT_ENQ, '1, '0);
    drain_results();
    repeat (5) send_beat(ACT_DEQ, '0, '0);
    drain_results();

    // Random phases that lean toward filling, draining or holding steady.
    while (beats_sent < 1100) begin
      phase_len = $urandom_range(30, 80);
      case ($urandom_range(0, 2))
        0:       enq_pct = 25;
        1:       enq_pct = 50;
        default: enq_pct = 80;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      repeat (phase_len)
        send_beat(($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ,
                  draw_data(), draw_priority());
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    // Wait for the last results and a few cycles more.
    item_valid = 1'b0;
    wait (outstanding == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sorted_priority_queue_core_test: PASS");
    end else begin
      $display("sorted_priority_queue_core_test: FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("sorted_priority_queue_core_test: FAIL");
    $finish;
  end

endmodule
